// File: rtl/ccs_pkg.sv
`default_nettype none

package ccs_pkg;

    localparam int VOLT_W     = 16;
    localparam int CUR_W      = 15;
    localparam int KEY_W      = 2;
    localparam int PHASE_W    = 3;
    localparam int POST_W     = 5;
    localparam int TMO_W      = 7;
    localparam int CNT_W      = 20;
    localparam int TICK_W     = 22;
    localparam int ACC_W      = 37;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    localparam logic [CNT_W-1:0]  CNT_MAX  = '1;
    localparam logic [TICK_W-1:0] TICK_MAX = '1;
    localparam logic [ACC_W-1:0]  ACC_MAX  = '1;

    localparam logic [KEY_W-1:0] KEY_CLICK = 2'd1;
    localparam logic [KEY_W-1:0] KEY_LONG  = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_IDX_VMAX    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_VMIN    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_IMAX    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_IMIN    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_POSTPONE = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_TIMEOUT = 3'd5;

    localparam logic [VOLT_W-1:0] RST_VMAX     = 16'd14500;
    localparam logic [VOLT_W-1:0] RST_VMIN     = 16'd13200;
    localparam logic [CUR_W-1:0]  RST_IMAX     = 15'd5000;
    localparam logic [CUR_W-1:0]  RST_IMIN     = 15'd500;
    localparam logic [POST_W-1:0] RST_POSTPONE = 5'd0;
    localparam logic [TMO_W-1:0]  RST_TIMEOUT  = 7'd24;

    typedef enum logic [PHASE_W-1:0] {
        PH_START = 3'd0,
        PH_DELAY = 3'd1,
        PH_CC    = 3'd2,
        PH_VMAX  = 3'd3,
        PH_VMIN  = 3'd4,
        PH_STOP  = 3'd5
    } t_phase;

    typedef struct packed {
        logic [VOLT_W-1:0] voltage_mv;
        logic [CUR_W-1:0]  current_ma;
        logic [KEY_W-1:0]  mode;
    } t_in_req;

    typedef struct packed {
        logic [PHASE_W-1:0] phase;
        logic [VOLT_W-1:0]  setpoint_mv;
        logic               power_enable;
        logic               trim_pulse;
        logic [TICK_W-1:0]  elapsed_ticks;
        logic [ACC_W-1:0]   charge_sum;
        logic               exit_pulse;
    } t_out_res;

    typedef struct packed {
        logic [VOLT_W-1:0] voltage_max_mv;
        logic [VOLT_W-1:0] voltage_min_mv;
        logic [CUR_W-1:0]  current_max_ma;
        logic [CUR_W-1:0]  current_min_ma;
        logic [POST_W-1:0] postpone_hours;
        logic [TMO_W-1:0]  timeout_hours;
    } t_cfg;

    typedef struct packed {
        t_phase            phase;
        logic [CNT_W-1:0]  countdown;
        logic [TICK_W-1:0] ticks;
        logic [ACC_W-1:0]  acc;
    } t_state;

endpackage

`default_nettype wire

// File: rtl/ccs_cfg_regs.sv
`default_nettype none

module ccs_cfg_regs (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic                             i_cfg_valid,
    input  wire logic [ccs_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  wire logic [ccs_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    output ccs_pkg::t_cfg                         o_cfg
);

    ccs_pkg::t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.voltage_max_mv <= ccs_pkg::RST_VMAX;
            r_cfg.voltage_min_mv <= ccs_pkg::RST_VMIN;
            r_cfg.current_max_ma <= ccs_pkg::RST_IMAX;
            r_cfg.current_min_ma <= ccs_pkg::RST_IMIN;
            r_cfg.postpone_hours <= ccs_pkg::RST_POSTPONE;
            r_cfg.timeout_hours  <= ccs_pkg::RST_TIMEOUT;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                ccs_pkg::CFG_IDX_VMAX: begin
                    r_cfg.voltage_max_mv <= i_cfg_data[ccs_pkg::VOLT_W-1:0];
                end
                ccs_pkg::CFG_IDX_VMIN: begin
                    r_cfg.voltage_min_mv <= i_cfg_data[ccs_pkg::VOLT_W-1:0];
                end
                ccs_pkg::CFG_IDX_IMAX: begin
                    r_cfg.current_max_ma <= i_cfg_data[ccs_pkg::CUR_W-1:0];
                end
                ccs_pkg::CFG_IDX_IMIN: begin
                    r_cfg.current_min_ma <= i_cfg_data[ccs_pkg::CUR_W-1:0];
                end
                ccs_pkg::CFG_IDX_POSTPONE: begin
                    r_cfg.postpone_hours <= i_cfg_data[ccs_pkg::POST_W-1:0];
                end
                ccs_pkg::CFG_IDX_TIMEOUT: begin
                    r_cfg.timeout_hours <= i_cfg_data[ccs_pkg::TMO_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

`default_nettype wire

// File: rtl/ccs_step.sv
`default_nettype none

module ccs_step #(
    parameter int TICKS_PER_HOUR = 36000
) (
    input  wire ccs_pkg::t_cfg    i_cfg,
    input  wire ccs_pkg::t_state  i_state,
    input  wire ccs_pkg::t_in_req i_req,
    output ccs_pkg::t_state   o_next_state,
    output ccs_pkg::t_out_res o_res
);

    localparam int TPH_W  = $clog2(TICKS_PER_HOUR + 1);
    localparam int PP_W   = ccs_pkg::POST_W + TPH_W;
    localparam int TO_W   = ccs_pkg::TMO_W + TPH_W;
    localparam int PCMP_W = (PP_W > ccs_pkg::CNT_W) ? PP_W : ccs_pkg::CNT_W;
    localparam int TCMP_W = (TO_W > ccs_pkg::TICK_W) ? TO_W : ccs_pkg::TICK_W;

    logic [PP_W-1:0]              post_ticks;
    logic [TO_W-1:0]              tmo_ticks;
    logic [ccs_pkg::CNT_W-1:0]    post_sat;
    logic [ccs_pkg::TICK_W-1:0]   tick_inc;
    logic [ccs_pkg::ACC_W:0]      acc_sum;
    logic [ccs_pkg::ACC_W-1:0]    acc_inc;
    logic                         click;
    logic                         longp;
    logic                         over;
    logic                         timed_out;
    logic                         trim;
    logic                         exitp;
    ccs_pkg::t_state              nxt;

    assign post_ticks = PP_W'(i_cfg.postpone_hours) * PP_W'(TICKS_PER_HOUR);
    assign tmo_ticks  = TO_W'(i_cfg.timeout_hours) * TO_W'(TICKS_PER_HOUR);
    assign post_sat   = (PCMP_W'(post_ticks) > PCMP_W'(ccs_pkg::CNT_MAX))
                      ? ccs_pkg::CNT_MAX : ccs_pkg::CNT_W'(post_ticks);

    assign tick_inc = (i_state.ticks == ccs_pkg::TICK_MAX)
                    ? i_state.ticks : i_state.ticks + 1'b1;
    assign acc_sum  = {1'b0, i_state.acc} + (ccs_pkg::ACC_W + 1)'(i_req.current_ma);
    assign acc_inc  = acc_sum[ccs_pkg::ACC_W] ? ccs_pkg::ACC_MAX
                                              : acc_sum[ccs_pkg::ACC_W-1:0];

    assign click     = (i_req.mode == ccs_pkg::KEY_CLICK);
    assign longp     = (i_req.mode == ccs_pkg::KEY_LONG);
    assign over      = (i_req.current_ma > i_cfg.current_max_ma);
    assign timed_out = (TCMP_W'(tick_inc) >= TCMP_W'(tmo_ticks));

    always_comb begin
        nxt   = i_state;
        trim  = 1'b0;
        exitp = 1'b0;
        case (i_state.phase)
            ccs_pkg::PH_START: begin
                if (click) begin
                    nxt.phase     = ccs_pkg::PH_DELAY;
                    nxt.countdown = post_sat;
                end
            end
            ccs_pkg::PH_DELAY: begin
                if (longp) begin
                    nxt.phase = ccs_pkg::PH_STOP;
                end else if (i_state.countdown == '0 || click) begin
                    nxt.phase = ccs_pkg::PH_CC;
                    nxt.ticks = '0;
                    nxt.acc   = '0;
                end else begin
                    nxt.countdown = i_state.countdown - 1'b1;
                end
            end
            ccs_pkg::PH_CC: begin
                nxt.ticks = tick_inc;
                nxt.acc   = acc_inc;
                if (click) begin
                    nxt.phase = ccs_pkg::PH_STOP;
                end else if (i_req.voltage_mv >= i_cfg.voltage_max_mv) begin
                    nxt.phase = ccs_pkg::PH_VMAX;
                end else begin
                    trim = over;
                end
            end
            ccs_pkg::PH_VMAX: begin
                nxt.ticks = tick_inc;
                nxt.acc   = acc_inc;
                if (click) begin
                    nxt.phase = ccs_pkg::PH_STOP;
                end else if (i_req.current_ma <= i_cfg.current_min_ma) begin
                    nxt.phase = ccs_pkg::PH_VMIN;
                end else begin
                    trim = over;
                end
            end
            ccs_pkg::PH_VMIN: begin
                nxt.ticks = tick_inc;
                nxt.acc   = acc_inc;
                if (click || timed_out) begin
                    nxt.phase = ccs_pkg::PH_STOP;
                end else begin
                    trim = over;
                end
            end
            ccs_pkg::PH_STOP: begin
                if (click) begin
                    exitp     = 1'b1;
                    nxt.phase = ccs_pkg::PH_START;
                end
            end
            default: begin
                nxt.phase = ccs_pkg::PH_START;
            end
        endcase
    end

    always_comb begin
        o_res.phase         = nxt.phase;
        o_res.setpoint_mv   = '0;
        o_res.power_enable  = 1'b0;
        o_res.trim_pulse    = trim;
        o_res.elapsed_ticks = nxt.ticks;
        o_res.charge_sum    = nxt.acc;
        o_res.exit_pulse    = exitp;
        case (nxt.phase)
            ccs_pkg::PH_CC, ccs_pkg::PH_VMAX: begin
                o_res.setpoint_mv  = i_cfg.voltage_max_mv;
                o_res.power_enable = 1'b1;
            end
            ccs_pkg::PH_VMIN: begin
                o_res.setpoint_mv  = i_cfg.voltage_min_mv;
                o_res.power_enable = 1'b1;
            end
            default: begin
            end
        endcase
    end

    assign o_next_state = nxt;

endmodule

`default_nettype wire

// File: rtl/cccv_charge_sequencer.sv
// Path: an accepted request is held in the input register, and its result is written to
// the result register once that register is empty or the output is not stalled.
// Throughput: one request per cycle while the output is not stalled; the input and
// result registers let a new request in while a finished result waits under stall.
// Reset: synchronous, active low; clears phase, countdown, counters, valid flags
// and loads the register defaults.
`default_nettype none

module cccv_charge_sequencer #(
    parameter int TICKS_PER_HOUR = 36000
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_in_valid,
    output logic                                 o_in_stall,
    input  wire ccs_pkg::t_in_req                i_in_data,
    output logic                                 o_out_valid,
    input  wire logic                            i_out_stall,
    output ccs_pkg::t_out_res                    o_out_data,
    input  wire logic                            i_cfg_valid,
    output logic                                 o_cfg_ready,
    input  wire logic [ccs_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  wire logic [ccs_pkg::CFG_DATA_W-1:0]  i_cfg_data
);

    ccs_pkg::t_cfg     cfg;
    ccs_pkg::t_state   r_state;
    ccs_pkg::t_state   n_state;
    ccs_pkg::t_in_req  r_in;
    ccs_pkg::t_out_res r_out;
    ccs_pkg::t_out_res n_out;
    logic              r_in_valid;
    logic              r_out_valid;
    logic              advance;

    assign o_cfg_ready = 1'b1;

    ccs_cfg_regs u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    ccs_step #(
        .TICKS_PER_HOUR (TICKS_PER_HOUR)
    ) u_step (
        .i_cfg        (cfg),
        .i_state      (r_state),
        .i_req        (r_in),
        .o_next_state (n_state),
        .o_res        (n_out)
    );

    assign advance    = r_in_valid && (!r_out_valid || !i_out_stall);
    assign o_in_stall = r_in_valid && !advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid      <= 1'b0;
            r_out_valid     <= 1'b0;
            r_state.phase     <= ccs_pkg::PH_START;
            r_state.countdown <= '0;
            r_state.ticks     <= '0;
            r_state.acc       <= '0;
        end else begin
            if (i_in_valid && !o_in_stall) begin
                r_in_valid <= 1'b1;
            end else if (advance) begin
                r_in_valid <= 1'b0;
            end
            if (advance) begin
                r_out_valid <= 1'b1;
                r_state     <= n_state;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && !o_in_stall) begin
            r_in <= i_in_data;
        end
        if (advance) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

`default_nettype wire

// File: rtl/ccs_checker.sv
`default_nettype none

module ccs_checker (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          o_out_valid,
    input  wire logic          i_out_stall,
    input  wire ccs_pkg::t_out_res o_out_data
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_data))
        else $error("result dropped or changed under stall");

    a_power_phase: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_out_data.power_enable ==
            (o_out_data.phase == ccs_pkg::PH_CC || o_out_data.phase == ccs_pkg::PH_VMAX
             || o_out_data.phase == ccs_pkg::PH_VMIN))
        else $error("power enable disagrees with phase");

    a_exit_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.exit_pulse |-> o_out_data.phase == ccs_pkg::PH_START)
        else $error("exit pulse outside return to start");

    a_trim_power: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.trim_pulse |-> o_out_data.power_enable)
        else $error("trim pulse while not charging");

    a_setpoint_off: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_out_data.power_enable |-> o_out_data.setpoint_mv == '0)
        else $error("setpoint nonzero while not charging");

endmodule

bind cccv_charge_sequencer ccs_checker u_ccs_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_out_data  (o_out_data)
);

`default_nettype wire
